[design/two_level_write_back_cache_core_defines.svh]
// assertion macros shared by the cache core
`ifndef TWO_LEVEL_WRITE_BACK_CACHE_CORE_DEFINES_SVH
`define TWO_LEVEL_WRITE_BACK_CACHE_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define TLC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define TLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tlc_pkg.sv]
package tlc_pkg;

  // geometry
  localparam int MEM_LINES  = 4096;
  localparam int LINE_BYTES = 64;
  localparam int WORD_BYTES = 4;
  localparam int SETS       = 256;
  localparam int ADDR_W     = 32;
  localparam int DATA_W     = WORD_BYTES * 8;
  localparam int LINE_W     = LINE_BYTES * 8;
  localparam int OFF_LSB    = $clog2(WORD_BYTES);
  localparam int IDX_LSB    = $clog2(LINE_BYTES);
  localparam int OFF_W      = IDX_LSB - OFF_LSB;
  localparam int IDX_W      = $clog2(SETS);
  localparam int TAG_LSB    = IDX_LSB + IDX_W;
  localparam int TAG_W      = ADDR_W - TAG_LSB;
  localparam int LNUM_W     = ADDR_W - IDX_LSB;
  localparam int MEM_IDX_W  = $clog2(MEM_LINES);

  // configuration
  localparam int COST_W    = 16;
  localparam int NUM_COSTS = 6;
  localparam int CFG_IDX_W = 3;
  localparam int TIME_W    = 32;
  localparam int OP_W      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_L1_RD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_WR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_RD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_WR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_RD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_WR = 3'd5;

  localparam logic [COST_W-1:0] RST_L1_RD  = 16'd1;
  localparam logic [COST_W-1:0] RST_L1_WR  = 16'd1;
  localparam logic [COST_W-1:0] RST_L2_RD  = 16'd10;
  localparam logic [COST_W-1:0] RST_L2_WR  = 16'd10;
  localparam logic [COST_W-1:0] RST_MEM_RD = 16'd100;
  localparam logic [COST_W-1:0] RST_MEM_WR = 16'd100;

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } tlc_op_t;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_DISP, ST_L1_CHK, ST_L2_RD, ST_L2_CHK,
    ST_MEM_RD, ST_MEM_DATA, ST_MEM_WR, ST_L2_ACC, ST_L1_FILL, ST_DONE
  } tlc_state_t;

  typedef struct packed {
    logic                 clr_step;
    logic                 accept;
    logic                 time_clr;
    logic                 l1_rd;
    logic                 l1_chk;
    logic                 l2_rd;
    logic                 l2_chk;
    logic                 mem_rd;
    logic                 mem_wr;
    logic                 l2_acc;
    logic                 l2_set_vic;
    logic                 l1_fill;
    logic                 op_done;
    logic                 add_en;
    logic [CFG_IDX_W-1:0] add_sel;
  } tlc_cmd_t;

  typedef struct packed {
    logic    clr_last;
    tlc_op_t req_op;
    logic    req_err;
    logic    l1_hit;
    logic    vic_dirty;
    logic    l2_hit;
    logic    l2_wr;
    logic    l2_vic_dirty;
    logic    out_free;
  } tlc_sts_t;

endpackage

[design/tlc_if.sv]
interface tlc_in_if import tlc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, opcode, address, write_data, input ready);
  modport sink   (input valid, opcode, address, write_data, output ready);
endinterface

interface tlc_out_if import tlc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [TIME_W-1:0] elapsed_time;
  logic              range_error;

  modport source (output valid, read_data, elapsed_time, range_error, input ready);
  modport sink   (input valid, read_data, elapsed_time, range_error, output ready);
endinterface

[design/tlc_ctrl.sv]
module tlc_ctrl import tlc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tlc_sts_t sts,
  output tlc_cmd_t cmd
);

  tlc_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:      if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:     if (in_valid) state_nxt = ST_DISP;
      ST_DISP: begin
        if (sts.req_op == OP_CLEAR || sts.req_op == OP_NOP || sts.req_err) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_L1_CHK;
        end
      end
      ST_L1_CHK:   state_nxt = sts.l1_hit ? ST_L1_FILL : ST_L2_RD;
      ST_L2_RD:    state_nxt = ST_L2_CHK;
      ST_L2_CHK:   state_nxt = sts.l2_hit ? ST_L2_ACC : ST_MEM_RD;
      ST_MEM_RD:   state_nxt = ST_MEM_DATA;
      ST_MEM_DATA: state_nxt = sts.l2_vic_dirty ? ST_MEM_WR : ST_L2_ACC;
      ST_MEM_WR:   state_nxt = ST_L2_ACC;
      ST_L2_ACC: begin
        if (!sts.l2_wr && sts.vic_dirty) begin
          state_nxt = ST_L2_RD;
        end else begin
          state_nxt = ST_L1_FILL;
        end
      end
      ST_L1_FILL:  state_nxt = ST_DONE;
      ST_DONE:     if (sts.out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLR:  cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_DISP: begin
        cmd.l1_rd    = 1'b1;
        cmd.time_clr = (sts.req_op == OP_CLEAR);
      end
      ST_L1_CHK: cmd.l1_chk = 1'b1;
      ST_L2_RD:  cmd.l2_rd = 1'b1;
      ST_L2_CHK: cmd.l2_chk = 1'b1;
      ST_MEM_RD: cmd.mem_rd = 1'b1;
      ST_MEM_DATA: begin
        cmd.add_en  = 1'b1;
        cmd.add_sel = CFG_MEM_RD;
      end
      ST_MEM_WR: begin
        cmd.mem_wr  = 1'b1;
        cmd.add_en  = 1'b1;
        cmd.add_sel = CFG_MEM_WR;
      end
      ST_L2_ACC: begin
        cmd.l2_acc     = 1'b1;
        cmd.add_en     = 1'b1;
        cmd.add_sel    = sts.l2_wr ? CFG_L2_WR : CFG_L2_RD;
        cmd.l2_set_vic = !sts.l2_wr && sts.vic_dirty;
      end
      ST_L1_FILL: begin
        cmd.l1_fill = 1'b1;
        cmd.add_en  = 1'b1;
        cmd.add_sel = (sts.req_op == OP_WRITE) ? CFG_L1_WR : CFG_L1_RD;
      end
      ST_DONE: cmd.op_done = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

[design/tlc_dp.sv]
module tlc_dp import tlc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tlc_cmd_t             cmd,
  output tlc_sts_t             sts,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic [ADDR_W-1:0]    in_address,
  input  logic [DATA_W-1:0]    in_write_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COST_W-1:0]    cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_W-1:0]    out_read_data,
  output logic [TIME_W-1:0]    out_elapsed_time,
  output logic                 out_range_error
);

  // memories
  logic [LINE_W-1:0] l1_data_m  [SETS];
  logic [TAG_W-1:0]  l1_tag_m   [SETS];
  logic [LINE_W-1:0] l2_data0_m [SETS];
  logic [LINE_W-1:0] l2_data1_m [SETS];
  logic [TAG_W-1:0]  l2_tag0_m  [SETS];
  logic [TAG_W-1:0]  l2_tag1_m  [SETS];
  logic [LINE_W-1:0] mem_m      [MEM_LINES];

  logic [SETS-1:0] l1_valid_r, l1_dirty_r;
  logic [SETS-1:0] l2_valid0_r, l2_dirty0_r, l2_valid1_r, l2_dirty1_r, l2_lru_r;

  logic [COST_W-1:0]    cost_r [NUM_COSTS];
  logic [TIME_W-1:0]    time_r;
  logic [MEM_IDX_W-1:0] clr_cnt_r;

  tlc_op_t           req_op_r;
  logic [ADDR_W-1:0] req_addr_r;
  logic [DATA_W-1:0] req_wdata_r;
  logic              req_err_r;
  logic [DATA_W-1:0] rdata_r;

  logic [LINE_W-1:0] l1_data_q, l2_data0_q, l2_data1_q, mem_q;
  logic [TAG_W-1:0]  l1_tag_q, l2_tag0_q, l2_tag1_q;

  logic [LINE_W-1:0] fill_r, vic_data_r;
  logic [TAG_W-1:0]  vic_tag_r;
  logic              vic_dirty_r, l1_hit_r;
  logic [LNUM_W-1:0] l2_line_r;
  logic              l2_wr_r, l2_way_r, l2_miss_r;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic [TIME_W-1:0] out_time_r;
  logic              out_err_r;

  logic [IDX_W-1:0]  req_idx, l2_set;
  logic [TAG_W-1:0]  req_tag, l2_tag, way_tag;
  logic [OFF_W-1:0]  req_off;
  logic [LNUM_W-1:0] req_line, vic_line;
  logic              l1_hit, hit0, hit1, line_ok, vline_ok, add_ok;
  logic              way_valid, way_dirty;
  logic [LINE_W-1:0] way_data, l2_wline, l1_wline;
  logic [DATA_W-1:0] fill_word;

  // address fields of the held request and of the current L2 access
  assign req_idx  = req_addr_r[TAG_LSB-1:IDX_LSB];
  assign req_tag  = req_addr_r[ADDR_W-1:TAG_LSB];
  assign req_off  = req_addr_r[IDX_LSB-1:OFF_LSB];
  assign req_line = req_addr_r[ADDR_W-1:IDX_LSB];
  assign l2_set   = l2_line_r[IDX_W-1:0];
  assign l2_tag   = l2_line_r[LNUM_W-1:IDX_W];

  // hit detection
  assign l1_hit = l1_valid_r[req_idx] && (l1_tag_q == req_tag);
  assign hit0   = l2_valid0_r[l2_set] && (l2_tag0_q == l2_tag);
  assign hit1   = l2_valid1_r[l2_set] && (l2_tag1_q == l2_tag);

  // chosen L2 way and its victim line
  assign way_data  = l2_way_r ? l2_data1_q : l2_data0_q;
  assign way_tag   = l2_way_r ? l2_tag1_q : l2_tag0_q;
  assign way_valid = l2_way_r ? l2_valid1_r[l2_set] : l2_valid0_r[l2_set];
  assign way_dirty = l2_way_r ? l2_dirty1_r[l2_set] : l2_dirty0_r[l2_set];
  assign vic_line  = {way_tag, l2_set};
  assign line_ok   = (l2_line_r < LNUM_W'(MEM_LINES));
  assign vline_ok  = (vic_line < LNUM_W'(MEM_LINES));
  assign add_ok    = cmd.add_en
                     && !((cmd.add_sel == CFG_MEM_RD) && !line_ok)
                     && !((cmd.add_sel == CFG_MEM_WR) && !vline_ok);

  // line written into L2 and line written into L1
  always_comb begin
    if (l2_wr_r) begin
      l2_wline = vic_data_r;
    end else if (l2_miss_r) begin
      l2_wline = mem_q;
    end else begin
      l2_wline = way_data;
    end
    fill_word = fill_r[req_off * DATA_W +: DATA_W];
    l1_wline  = fill_r;
    if (req_op_r == OP_WRITE) begin
      l1_wline[req_off * DATA_W +: DATA_W] = req_wdata_r;
    end
  end

  // status to controller
  always_comb begin
    sts.clr_last     = (clr_cnt_r == MEM_IDX_W'(MEM_LINES - 1));
    sts.req_op       = req_op_r;
    sts.req_err      = req_err_r;
    sts.l1_hit       = l1_hit;
    sts.vic_dirty    = vic_dirty_r;
    sts.l2_hit       = hit0 || hit1;
    sts.l2_wr        = l2_wr_r;
    sts.l2_vic_dirty = way_valid && way_dirty;
    sts.out_free     = !out_valid_r || out_ready;
  end

  // L1 memories
  always_ff @(posedge clk) begin
    if (cmd.l1_rd) begin
      l1_data_q <= l1_data_m[req_idx];
      l1_tag_q  <= l1_tag_m[req_idx];
    end
    if (cmd.l1_fill) begin
      l1_data_m[req_idx] <= l1_wline;
      l1_tag_m[req_idx]  <= req_tag;
    end
  end

  // L2 memories, one per way
  always_ff @(posedge clk) begin
    if (cmd.l2_rd) begin
      l2_data0_q <= l2_data0_m[l2_set];
      l2_data1_q <= l2_data1_m[l2_set];
      l2_tag0_q  <= l2_tag0_m[l2_set];
      l2_tag1_q  <= l2_tag1_m[l2_set];
    end
    if (cmd.l2_acc && !l2_way_r) begin
      l2_data0_m[l2_set] <= l2_wline;
      l2_tag0_m[l2_set]  <= l2_tag;
    end
    if (cmd.l2_acc && l2_way_r) begin
      l2_data1_m[l2_set] <= l2_wline;
      l2_tag1_m[l2_set]  <= l2_tag;
    end
  end

  // backing memory: clearing pass or victim write, one read port
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      mem_q <= mem_m[l2_line_r[MEM_IDX_W-1:0]];
    end
    if (cmd.clr_step) begin
      mem_m[clr_cnt_r] <= '0;
    end else if (cmd.mem_wr && vline_ok) begin
      mem_m[vic_line[MEM_IDX_W-1:0]] <= way_data;
    end
  end

  // valid, dirty and lru bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_valid_r  <= '0;
      l1_dirty_r  <= '0;
      l2_valid0_r <= '0;
      l2_dirty0_r <= '0;
      l2_valid1_r <= '0;
      l2_dirty1_r <= '0;
      l2_lru_r    <= '0;
    end else begin
      if (cmd.l1_fill) begin
        l1_valid_r[req_idx] <= 1'b1;
        if (req_op_r == OP_WRITE) begin
          l1_dirty_r[req_idx] <= 1'b1;
        end else if (!l1_hit_r) begin
          l1_dirty_r[req_idx] <= 1'b0;
        end
      end
      if (cmd.l2_acc) begin
        l2_lru_r[l2_set] <= l2_way_r;
        if (l2_way_r) begin
          l2_valid1_r[l2_set] <= 1'b1;
          if (l2_wr_r) begin
            l2_dirty1_r[l2_set] <= 1'b1;
          end else if (l2_miss_r) begin
            l2_dirty1_r[l2_set] <= 1'b0;
          end
        end else begin
          l2_valid0_r[l2_set] <= 1'b1;
          if (l2_wr_r) begin
            l2_dirty0_r[l2_set] <= 1'b1;
          end else if (l2_miss_r) begin
            l2_dirty0_r[l2_set] <= 1'b0;
          end
        end
      end
    end
  end

  // request capture and line buffers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_op_r    <= tlc_op_t'(in_opcode);
      req_addr_r  <= in_address;
      req_wdata_r <= in_write_data;
      req_err_r   <= (in_opcode == OP_READ || in_opcode == OP_WRITE)
                     && (in_address[ADDR_W-1:IDX_LSB] >= LNUM_W'(MEM_LINES));
      rdata_r     <= '0;
    end
    if (cmd.l1_chk) begin
      l1_hit_r <= l1_hit;
      if (l1_hit) begin
        fill_r <= l1_data_q;
      end else begin
        vic_data_r  <= l1_data_q;
        vic_tag_r   <= l1_tag_q;
        vic_dirty_r <= l1_valid_r[req_idx] && l1_dirty_r[req_idx];
        l2_line_r   <= req_line;
        l2_wr_r     <= 1'b0;
      end
    end
    if (cmd.l2_chk) begin
      l2_miss_r <= !(hit0 || hit1);
      if (hit0) begin
        l2_way_r <= 1'b0;
      end else if (hit1) begin
        l2_way_r <= 1'b1;
      end else begin
        l2_way_r <= !l2_lru_r[l2_set];
      end
    end
    if (cmd.l2_acc && !l2_wr_r) begin
      fill_r <= l2_wline;
    end
    if (cmd.l2_set_vic) begin
      l2_line_r <= {vic_tag_r, req_idx};
      l2_wr_r   <= 1'b1;
    end
    if (cmd.l1_fill && req_op_r == OP_READ) begin
      rdata_r <= fill_word;
    end
  end

  // costs, time total and clearing counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_r[CFG_L1_RD]  <= RST_L1_RD;
      cost_r[CFG_L1_WR]  <= RST_L1_WR;
      cost_r[CFG_L2_RD]  <= RST_L2_RD;
      cost_r[CFG_L2_WR]  <= RST_L2_WR;
      cost_r[CFG_MEM_RD] <= RST_MEM_RD;
      cost_r[CFG_MEM_WR] <= RST_MEM_WR;
      time_r             <= '0;
      clr_cnt_r          <= '0;
    end else begin
      if (cfg_we && cfg_index < CFG_IDX_W'(NUM_COSTS)) begin
        cost_r[cfg_index] <= cfg_data;
      end
      if (cmd.time_clr) begin
        time_r <= '0;
      end else if (add_ok) begin
        time_r <= time_r + TIME_W'(cost_r[cmd.add_sel]);
      end
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op_done) begin
      out_data_r <= rdata_r;
      out_time_r <= time_r;
      out_err_r  <= req_err_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_data_r;
  assign out_elapsed_time = out_time_r;
  assign out_range_error  = out_err_r;

endmodule

[design/two_level_write_back_cache_core.sv]
// two-level write-back cache core, one item at a time
// an L1 miss may need two L2 accesses that each miss and write back to memory
// the next item is accepted only after the result is registered
// reset: synchronous, then a clearing pass over all 4096 lines of the backing
// memory with no items accepted; cost registers take their defaults at reset
`include "two_level_write_back_cache_core_defines.svh"

module two_level_write_back_cache_core import tlc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  tlc_in_if.sink               in_ch,
  tlc_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COST_W-1:0]    cfg_data
);

  tlc_cmd_t cmd;
  tlc_sts_t sts;

  // sequencer
  tlc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // caches, memory, time and output register
  tlc_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_ch.opcode),
    .in_address       (in_ch.address),
    .in_write_data    (in_ch.write_data),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_read_data    (out_ch.read_data),
    .out_elapsed_time (out_ch.elapsed_time),
    .out_range_error  (out_ch.range_error)
  );

  // checks
  `TLC_ASSERT_NEXT(a_one_beat, in_ch.valid && in_ch.ready, !in_ch.ready, "second beat in flight")
  `TLC_ASSERT_SAME(a_l2_wr_dirty, cmd.l2_acc && sts.l2_wr, sts.vic_dirty, "clean victim written")
  `TLC_ASSERT_SAME(a_mem_wr_dirty, cmd.mem_wr, sts.l2_vic_dirty, "clean L2 victim to memory")
  `TLC_ASSERT_SAME(a_out_free, cmd.op_done, sts.out_free, "result register overwritten")

endmodule

[bench/tb_two_level_write_back_cache_core.sv]
module tb_two_level_write_back_cache_core;
  import tlc_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_SHOWN   = 10;
  localparam int SETTLE      = 40;
  localparam int LONG_HOLD   = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct {
    logic [DATA_W-1:0] read_data;
    logic [TIME_W-1:0] elapsed_time;
    logic              range_error;
  } cache_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COST_W-1:0] cfg_data;

  tlc_in_if  in_ch ();
  tlc_out_if out_ch ();

  two_level_write_back_cache_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // shadow copy of the cache hierarchy
  logic [COST_W-1:0] cost_reg [NUM_COSTS];
  logic [LINE_W-1:0] l1_data [SETS];
  logic [TAG_W-1:0]  l1_tag [SETS];
  bit                l1_valid [SETS];
  bit                l1_dirty [SETS];
  logic [LINE_W-1:0] l2_data [2*SETS];
  logic [TAG_W-1:0]  l2_tag [2*SETS];
  bit                l2_valid [2*SETS];
  bit                l2_dirty [2*SETS];
  bit                l2_lru [SETS];
  logic [LINE_W-1:0] mem_line [MEM_LINES];
  logic [TIME_W-1:0] time_acc;

  cache_result_t pending_results[$];
  int src_idle_pct;
  int snk_idle_pct;
  int hold_left;
  int mismatches;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // shadow hierarchy reset
  task automatic shadow_reset();
    cost_reg[CFG_L1_RD]  = RST_L1_RD;
    cost_reg[CFG_L1_WR]  = RST_L1_WR;
    cost_reg[CFG_L2_RD]  = RST_L2_RD;
    cost_reg[CFG_L2_WR]  = RST_L2_WR;
    cost_reg[CFG_MEM_RD] = RST_MEM_RD;
    cost_reg[CFG_MEM_WR] = RST_MEM_WR;
    for (int i = 0; i < SETS; i++) begin
      l1_data[i] = '0; l1_tag[i] = '0; l1_valid[i] = 0; l1_dirty[i] = 0; l2_lru[i] = 0;
    end
    for (int i = 0; i < 2*SETS; i++) begin
      l2_data[i] = '0; l2_tag[i] = '0; l2_valid[i] = 0; l2_dirty[i] = 0;
    end
    for (int i = 0; i < MEM_LINES; i++) mem_line[i] = '0;
    time_acc = '0;
  endtask

  // one line move to or from backing memory
  function automatic void mem_xfer(input logic [LNUM_W-1:0] lnum,
                                   inout logic [LINE_W-1:0] blk, input bit wr);
    if (lnum >= MEM_LINES) return;
    if (wr) begin
      mem_line[lnum[MEM_IDX_W-1:0]] = blk;
      time_acc += TIME_W'(cost_reg[CFG_MEM_WR]);
    end else begin
      blk = mem_line[lnum[MEM_IDX_W-1:0]];
      time_acc += TIME_W'(cost_reg[CFG_MEM_RD]);
    end
  endfunction

  // one line move through the two-way L2
  function automatic void l2_xfer(input logic [LNUM_W-1:0] lnum,
                                  inout logic [LINE_W-1:0] blk, input bit wr);
    logic [IDX_W-1:0] set;
    logic [TAG_W-1:0] tag;
    logic [LINE_W-1:0] fresh;
    int base;
    int way;
    int slot;
    set  = lnum[IDX_W-1:0];
    tag  = lnum[LNUM_W-1:IDX_W];
    base = 2 * set;
    if (l2_valid[base] && l2_tag[base] == tag) way = 0;
    else if (l2_valid[base+1] && l2_tag[base+1] == tag) way = 1;
    else begin
      way  = l2_lru[set] ? 0 : 1;
      slot = base + way;
      fresh = '0;
      mem_xfer(lnum, fresh, 1'b0);
      if (l2_valid[slot] && l2_dirty[slot])
        mem_xfer({l2_tag[slot], set}, l2_data[slot], 1'b1);
      l2_data[slot]  = fresh;
      l2_valid[slot] = 1;
      l2_tag[slot]   = tag;
      l2_dirty[slot] = 0;
    end
    slot = base + way;
    l2_lru[set] = way[0];
    if (wr) begin
      l2_data[slot]  = blk;
      l2_dirty[slot] = 1;
      time_acc += TIME_W'(cost_reg[CFG_L2_WR]);
    end else begin
      blk = l2_data[slot];
      time_acc += TIME_W'(cost_reg[CFG_L2_RD]);
    end
  endfunction

  // word access through the direct-mapped L1
  function automatic logic [DATA_W-1:0] l1_word(input logic [ADDR_W-1:0] addr,
                                                input logic [DATA_W-1:0] wdata,
                                                input bit wr);
    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tag;
    logic [LINE_W-1:0] fresh;
    int bit_off;
    idx = addr[TAG_LSB-1:IDX_LSB];
    tag = addr[ADDR_W-1:TAG_LSB];
    bit_off = 8 * (addr[IDX_LSB-1:OFF_LSB] * WORD_BYTES);
    if (!l1_valid[idx] || l1_tag[idx] != tag) begin
      fresh = '0;
      l2_xfer(addr[ADDR_W-1:IDX_LSB], fresh, 1'b0);
      if (l1_valid[idx] && l1_dirty[idx])
        l2_xfer({l1_tag[idx], idx}, l1_data[idx], 1'b1);
      l1_data[idx]  = fresh;
      l1_valid[idx] = 1;
      l1_tag[idx]   = tag;
      l1_dirty[idx] = 0;
    end
    if (wr) begin
      l1_data[idx][bit_off +: DATA_W] = wdata;
      l1_dirty[idx] = 1;
      time_acc += TIME_W'(cost_reg[CFG_L1_WR]);
      return '0;
    end
    time_acc += TIME_W'(cost_reg[CFG_L1_RD]);
    return l1_data[idx][bit_off +: DATA_W];
  endfunction

  function automatic cache_result_t predict_access(input tlc_op_t op,
                                                   input logic [ADDR_W-1:0] addr,
                                                   input logic [DATA_W-1:0] wdata);
    cache_result_t r;
    r.read_data = '0;
    r.range_error = 1'b0;
    if (op == OP_CLEAR) time_acc = '0;
    else if (op == OP_READ || op == OP_WRITE) begin
      if (addr[ADDR_W-1:IDX_LSB] >= MEM_LINES) r.range_error = 1'b1;
      else if (op == OP_READ) r.read_data = l1_word(addr, '0, 1'b0);
      else void'(l1_word(addr, wdata, 1'b1));
    end
    r.elapsed_time = time_acc;
    return r;
  endfunction

  // cycle count and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_two_level_write_back_cache_core failed");
      $finish;
    end
  end

  // result side: random stalls plus long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // result check against the oldest prediction
  always @(posedge clk) begin
    cache_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < MAX_SHOWN) $display("result beat with nothing pending");
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.read_data !== exp_r.read_data ||
            out_ch.elapsed_time !== exp_r.elapsed_time ||
            out_ch.range_error !== exp_r.range_error) begin
          mismatches <= mismatches + 1;
          if (mismatches < MAX_SHOWN)
            $display("mismatch: exp data %h time %h err %b, got data %h time %h err %b",
                     exp_r.read_data, exp_r.elapsed_time, exp_r.range_error,
                     out_ch.read_data, out_ch.elapsed_time, out_ch.range_error);
        end
      end
    end
  end

  // offer one beat and predict it once accepted
  task automatic send_item(input tlc_op_t op, input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] wdata);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.address    <= addr;
    in_ch.write_data <= wdata;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(predict_access(op, addr, wdata));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_cost(input logic [CFG_IDX_W-1:0] idx, input logic [COST_W-1:0] val);
    wait_drained();
    repeat (20) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < NUM_COSTS) cost_reg[idx] = val;
  endtask

  task automatic write_all_costs(input logic [COST_W-1:0] l1r, input logic [COST_W-1:0] l1w,
                                 input logic [COST_W-1:0] l2r, input logic [COST_W-1:0] l2w,
                                 input logic [COST_W-1:0] mr, input logic [COST_W-1:0] mw);
    write_cost(CFG_L1_RD, l1r);
    write_cost(CFG_L1_WR, l1w);
    write_cost(CFG_L2_RD, l2r);
    write_cost(CFG_L2_WR, l2w);
    write_cost(CFG_MEM_RD, mr);
    write_cost(CFG_MEM_WR, mw);
  endtask

  // address mostly from a few tags and indexes so lines collide
  function automatic logic [ADDR_W-1:0] pick_address();
    logic [ADDR_W-1:0] a;
    int pick;
    a = $urandom;
    pick = $urandom_range(99);
    if (pick < 70) begin
      a[ADDR_W-1:TAG_LSB]  = TAG_W'($urandom_range(3));
      a[TAG_LSB-1:IDX_LSB] = IDX_W'($urandom_range(7));
    end else if (pick < 90) begin
      a[ADDR_W-1:TAG_LSB] = TAG_W'($urandom_range(MEM_LINES / SETS - 1));
    end
    return a;
  endfunction

  function automatic tlc_op_t pick_op();
    int pick;
    pick = $urandom_range(99);
    if (pick < 47) return OP_READ;
    if (pick < 94) return OP_WRITE;
    if (pick < 97) return OP_CLEAR;
    return OP_NOP;
  endfunction

  // corner cases: cold miss, conflicts, evictions, range, clear, unused opcode
  task automatic test_directed();
    send_item(OP_READ,  32'h0000_0000, 32'hFFFF_FFFF);
    send_item(OP_WRITE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(OP_READ,  32'h0000_0003, 32'h0);
    send_item(OP_WRITE, 32'h0000_017F, 32'hA5C3_3C5A);
    send_item(OP_READ,  32'h0000_017C, 32'h0);
    send_item(OP_WRITE, 32'h0000_4140, 32'h1234_5678);
    send_item(OP_WRITE, 32'h0000_8140, 32'h0BAD_F00D);
    send_item(OP_WRITE, 32'h0000_C140, 32'hDEAD_BEEF);
    send_item(OP_READ,  32'h0000_0140, 32'h0);
    send_item(OP_READ,  32'h0000_4144, 32'h0);
    send_item(OP_READ,  32'h0000_8140, 32'h0);
    send_item(OP_WRITE, 32'h0003_FFFF, 32'h0000_0000);
    send_item(OP_READ,  32'h0003_FFFC, 32'h0);
    send_item(OP_WRITE, 32'h0004_0000, 32'hFFFF_FFFF);
    send_item(OP_READ,  32'hFFFF_FFFF, 32'h0);
    send_item(OP_NOP,   32'h0000_0000, 32'h0);
    send_item(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_READ,  32'h0000_4140, 32'h0);
    send_item(OP_WRITE, 32'h0001_0000, 32'h8000_0001);
    send_item(OP_READ,  32'h0000_0000, 32'h0);
  endtask

  task automatic test_random_mix(input int n);
    for (int i = 0; i < n; i++) send_item(pick_op(), pick_address(), $urandom);
  endtask

  // costs at the extremes, unused register indexes ignored
  task automatic test_cost_settings();
    write_all_costs(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    test_random_mix(20);
    write_all_costs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_cost(CFG_SPARE_LO, 16'h1234);
    write_cost(CFG_SPARE_HI, 16'hFFFF);
    test_random_mix(40);
  endtask

  // long result stall while items keep coming
  task automatic test_output_stall();
    hold_left = LONG_HOLD;
    test_random_mix(20);
  endtask

  // sender goes quiet until every result is back
  task automatic test_drain_pause();
    test_random_mix(15);
    wait_drained();
    test_random_mix(15);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_READ;
    in_ch.address = '0;
    in_ch.write_data = '0;
    out_ch.ready = 1'b0;
    src_idle_pct = 24;
    snk_idle_pct = 67;
    hold_left = 0;
    mismatches = 0;
    cycles = 0;
    shadow_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_cost_settings();
    write_all_costs(COST_W'($urandom), COST_W'($urandom), COST_W'($urandom),
                    COST_W'($urandom), COST_W'($urandom), COST_W'($urandom));
    test_random_mix(350);
    test_output_stall();
    src_idle_pct = 67;
    snk_idle_pct = 24;
    write_all_costs(RST_L1_RD, RST_L1_WR, RST_L2_RD, RST_L2_WR, RST_MEM_RD, RST_MEM_WR);
    test_random_mix(330);
    test_drain_pause();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_all_costs(COST_W'($urandom), COST_W'($urandom), COST_W'($urandom),
                    COST_W'($urandom), COST_W'($urandom), COST_W'($urandom));
    test_random_mix(350);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0)
      $display("tb_two_level_write_back_cache_core passed");
    else
      $display("tb_two_level_write_back_cache_core failed");
    $finish;
  end

endmodule
